// ----- hdl/dhu_pkg.sv -----
// shared types, constants and character helpers for the percent-pair unescaper
// no dependencies
package dhu_pkg;

  localparam logic [7:0] PCT_CHAR    = 8'h25;
  localparam logic [7:0] VALUE_LIMIT = 8'h80;
  localparam int         MAX_RESULTS = 4;
  localparam int         QUEUE_DEPTH = 2;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] res_cnt_t;

  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    res_cnt_t                    count;
    logic                        last;
  } group_t;

  function automatic logic is_hex(input byte_t b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
           (b >= 8'h61 && b <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input byte_t b);
    logic [7:0] d;
    d = 8'h00;
    if (b >= 8'h30 && b <= 8'h39) begin
      d = b - 8'h30;
    end else if (b >= 8'h41 && b <= 8'h46) begin
      d = b - 8'h41 + 8'd10;
    end else if (b >= 8'h61 && b <= 8'h66) begin
      d = b - 8'h61 + 8'd10;
    end
    return d[3:0];
  endfunction

  // true when the first k bytes of q can still start or form a run
  function automatic logic can_continue(input logic [3:0][7:0] q, input res_cnt_t k);
    logic ok;
    ok = (q[0] == PCT_CHAR);
    if (k >= 3'd2 && q[1] != PCT_CHAR) begin
      ok = 1'b0;
    end
    if (k >= 3'd3 && (!is_hex(q[2]) || ({hex_val(q[2]), 4'h0} >= VALUE_LIMIT))) begin
      ok = 1'b0;
    end
    if (k >= 3'd4 && !is_hex(q[3])) begin
      ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

// ----- hdl/dhu_front.sv -----
// front end: accepts bytes, tracks the held prefix and builds one result group per byte
// depends on dhu_pkg
module dhu_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_end_of_string,
  input  logic            q_full,
  output logic            push,
  output dhu_pkg::group_t push_group
);

  logic [2:0][7:0]  pend_r;
  logic [2:0][7:0]  pend_nxt;
  logic [1:0]       pcnt_r;
  logic [1:0]       pcnt_nxt;
  logic             accept;
  dhu_pkg::group_t  grp;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic [3:0][7:0] seq;
    logic [2:0]      len;
    logic [2:0]      n;
    logic            done;
    seq  = {in_byte, pend_r};
    seq[pcnt_r] = in_byte;
    len  = {1'b0, pcnt_r} + 3'd1;
    n    = 3'd0;
    done = 1'b0;
    grp  = '0;
    for (int it = 0; it < 4; it++) begin
      if (!done && len != 3'd0) begin
        if (dhu_pkg::can_continue(seq, len)) begin
          if (len == 3'd4) begin
            grp.bytes[n[1:0]] = {dhu_pkg::hex_val(seq[2]), dhu_pkg::hex_val(seq[3])};
            n   = n + 3'd1;
            len = 3'd0;
          end
          done = 1'b1;
        end else begin
          grp.bytes[n[1:0]] = seq[0];
          n      = n + 3'd1;
          seq[0] = seq[1];
          seq[1] = seq[2];
          seq[2] = seq[3];
          len    = len - 3'd1;
        end
      end
    end
    if (in_end_of_string) begin
      for (int i = 0; i < 3; i++) begin
        if (3'(i) < len) begin
          grp.bytes[n[1:0]] = seq[i];
          n = n + 3'd1;
        end
      end
      len = 3'd0;
    end
    grp.count = n;
    grp.last  = in_end_of_string;
    pend_nxt  = seq[2:0];
    pcnt_nxt  = len[1:0];
  end

  assign push       = accept && (grp.count != 3'd0);
  assign push_group = grp;

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r <= 2'd0;
    end else if (accept) begin
      pcnt_r <= pcnt_nxt;
    end
  end

  a_eos_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_end_of_string |-> push)
    else $error("string end produced no result");

  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_end_of_string |=> pcnt_r == 2'd0)
    else $error("held bytes survive string end");

endmodule

// ----- hdl/dhu_queue.sv -----
// short queue of result groups between front and back
// depends on dhu_pkg
module dhu_queue #(
  parameter int DEPTH = dhu_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dhu_pkg::group_t push_group,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output dhu_pkg::group_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  dhu_pkg::group_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_group;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full) && !(pop && !not_empty))
    else $error("queue overflow or underflow");

endmodule

// ----- hdl/dhu_back.sv -----
// back end: unpacks result groups into single output bytes
// depends on dhu_pkg
module dhu_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_not_empty,
  input  dhu_pkg::group_t q_head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  dhu_pkg::group_t cur_r;
  logic            cur_valid_r;
  logic [1:0]      idx_r;
  logic            final_byte;
  logic            load;

  assign final_byte = ({1'b0, idx_r} == cur_r.count - 3'd1);
  assign load       = !cur_valid_r || (out_ready && final_byte);
  assign pop        = load && q_not_empty;

  assign out_valid = cur_valid_r;
  assign out_byte  = cur_r.bytes[idx_r];
  assign out_last  = cur_r.last && final_byte;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (load) begin
      cur_valid_r <= q_not_empty;
      idx_r       <= 2'd0;
    end else if (out_ready) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  a_group_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (cur_r.count != 3'd0 && {1'b0, idx_r} < cur_r.count))
    else $error("output index outside group");

endmodule

// ----- hdl/double_percent_hex_unescaper_top.sv -----
// top level of the percent-pair unescaper: front, group queue and back
// depends on dhu_pkg, dhu_front, dhu_queue, dhu_back
//
//   channel  ports                                  role
//   in       in_valid in_ready in_byte              escaped byte, string end mark
//            in_end_of_string
//   out      out_valid out_ready out_byte out_last  unescaped byte, final mark
//
// one input byte per cycle; each byte yields a group of zero to four output bytes
// the back end sends one group byte per cycle while out_ready is high
// input stalls only when the group queue (QUEUE_DEPTH entries) is full
// synchronous active-low reset clears held-byte count, queue and output valid
module double_percent_hex_unescaper_top #(
  parameter int QUEUE_DEPTH = dhu_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_string,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_not_empty;
  dhu_pkg::group_t push_group;
  dhu_pkg::group_t q_head;

  dhu_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .q_full           (q_full),
    .push             (push),
    .push_group       (push_group)
  );

  dhu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_group (push_group),
    .full       (q_full),
    .pop        (pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  dhu_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_last    (out_last)
  );

endmodule

// ----- verif/unescape_checker.sv -----
// watches both channels of the percent-pair unescaper, predicts each output character
// and compares it with what the block sends; depends on dhu_pkg
module unescape_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_string,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       out_last,
  output int         mismatches,
  output int         results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    dhu_pkg::byte_t data;
    logic           last;
  } out_char_t;

  out_char_t        expected_chars[$];
  logic [2:0][7:0]  held;
  int               held_n = 0;
  int               error_total = 0;

  function automatic bit hex_char(input dhu_pkg::byte_t c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [3:0] hex_nibble(input dhu_pkg::byte_t c);
    dhu_pkg::byte_t v;
    v = 8'h00;
    if (c >= "0" && c <= "9") begin
      v = c - "0";
    end else if (c >= "A" && c <= "F") begin
      v = c - "A" + 8'd10;
    end else if (c >= "a" && c <= "f") begin
      v = c - "a" + 8'd10;
    end
    return v[3:0];
  endfunction

  // can the first k characters still begin or complete an escape
  function automatic bit run_viable(input logic [3:0][7:0] s, input int k);
    if (s[0] != dhu_pkg::PCT_CHAR) return 1'b0;
    if (k >= 2 && s[1] != dhu_pkg::PCT_CHAR) return 1'b0;
    if (k >= 3 && (!hex_char(s[2]) ||
                   {hex_nibble(s[2]), 4'h0} >= dhu_pkg::VALUE_LIMIT)) return 1'b0;
    if (k >= 4 && !hex_char(s[3])) return 1'b0;
    return 1'b1;
  endfunction

  task automatic unescape_char(input dhu_pkg::byte_t c, input logic eos);
    logic [3:0][7:0] seq;
    logic [3:0][7:0] outs;
    out_char_t       item;
    int              len;
    int              n;
    bit              settled;
    seq = '0;
    outs = '0;
    n = 0;
    settled = 1'b0;
    for (int i = 0; i < held_n; i++) seq[i] = held[i];
    seq[held_n] = c;
    len = held_n + 1;
    while (len > 0 && !settled) begin
      if (run_viable(seq, len)) begin
        if (len == 4) begin
          outs[n] = {hex_nibble(seq[2]), hex_nibble(seq[3])};
          n++;
          len = 0;
        end
        settled = 1'b1;
      end else begin
        // first character goes out as is, rescan from the next one
        outs[n] = seq[0];
        n++;
        for (int i = 0; i < 3; i++) seq[i] = seq[i + 1];
        len--;
      end
    end
    if (eos) begin
      for (int i = 0; i < len; i++) begin
        outs[n] = seq[i];
        n++;
      end
      len = 0;
    end
    for (int i = 0; i < len; i++) held[i] = seq[i];
    held_n = len;
    for (int i = 0; i < n; i++) begin
      item.data = outs[i];
      item.last = eos && (i == n - 1);
      expected_chars.push_back(item);
    end
  endtask

  always @(posedge clk) begin
    out_char_t want;
    if (!rst_n) begin
      held_n = 0;
      expected_chars.delete();
    end else begin
      if (in_valid && in_ready) begin
        unescape_char(in_byte, in_end_of_string);
      end
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected transaction out_byte %02h out_last %0b",
                   $time, out_byte, out_last);
          error_total++;
        end else begin
          want = expected_chars.pop_front();
          if (out_byte !== want.data) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, want.data, out_byte);
            error_total++;
          end
          if (out_last !== want.last) begin
            $display("%0t: out_last expected %0b actual %0b", $time, want.last, out_last);
            error_total++;
          end
        end
      end
    end
    mismatches  <= error_total;
    results_due <= expected_chars.size();
  end

endmodule

// ----- verif/testbench.sv -----
// stimulus, handshake pacing and verdict for double_percent_hex_unescaper_top
// depends on the rtl under hdl and on unescape_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS  = 350;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 20;
  localparam int LONG_HOLD     = 250;
  localparam int HOLD_AT       = 60;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_of_string = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;
  int         mismatches;
  int         results_due;

  int         idle_cycles = 0;
  int         random_sent = 0;
  int         delivered = 0;
  bit         rush_in = 1'b0;
  bit         rush_out = 1'b0;
  logic [7:0] text[$];

  double_percent_hex_unescaper_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last         (out_last)
  );

  unescape_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last         (out_last),
    .mismatches       (mismatches),
    .results_due      (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("double_percent_hex_unescaper_top regression: fail");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic eos);
    int gap;
    gap = rush_in ? 0 : $urandom_range(0, 7);
    if ($urandom_range(0, 19) == 0) rush_in = !rush_in;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_byte          <= c;
    in_end_of_string <= eos;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  function automatic logic [7:0] pick(input string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  task automatic add_token();
    int n;
    string any_hex;
    any_hex = "0123456789abcdefABCDEF";
    n = $urandom_range(1, 3);
    case ($urandom_range(0, 11)) inside
      [0:4]: begin
        text.push_back("%");
        text.push_back("%");
        text.push_back(pick("01234567"));
        text.push_back(pick(any_hex));
      end
      5: text.push_back(8'($urandom_range(0, 255)));
      6: begin
        // first digit too large for the value limit
        text.push_back("%");
        text.push_back("%");
        text.push_back(pick("89abcdefABCDEF"));
        text.push_back(pick(any_hex));
      end
      7: begin
        text.push_back("%");
        text.push_back("%");
        if ($urandom_range(0, 1)) begin
          text.push_back(pick("/:@G`g%z"));
          text.push_back(pick(any_hex));
        end else begin
          text.push_back(pick("01234567"));
          text.push_back(pick("/:@G`g%z"));
        end
      end
      8: begin
        text.push_back("%");
        text.push_back(8'($urandom_range(0, 255)));
      end
      9: begin
        // cut short, often left held at the end of the string
        text.push_back("%");
        if (n >= 2) text.push_back("%");
        if (n >= 3) text.push_back(pick("01234567"));
      end
      default: begin
        repeat (n) text.push_back(8'($urandom_range(32, 126)));
      end
    endcase
  endtask

  initial begin
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = rush_out ? 0 : $urandom_range(0, 7);
      if ($urandom_range(0, 19) == 0) rush_out = !rush_out;
      if (delivered == HOLD_AT) stall = LONG_HOLD;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      delivered++;
    end
  end

  initial begin
    bit paused;
    paused = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_char(8'h00, 1'b1);
    send_char(8'hff, 1'b1);
    send_text("%%7F%%0a");
    send_text("%%80");
    send_text("%%G1");
    send_text("%%5");
    send_text("%%7x");
    wait_for_results();

    while (random_sent < RANDOM_ITEMS) begin
      text.delete();
      repeat ($urandom_range(1, 5)) add_token();
      for (int i = 0; i < text.size(); i++) begin
        send_char(text[i], i == text.size() - 1);
        random_sent++;
      end
      if (!paused && random_sent >= 250) begin
        paused = 1'b1;
        wait_for_results();
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_due == 0) begin
      $display("double_percent_hex_unescaper_top regression: pass");
    end else begin
      $display("double_percent_hex_unescaper_top regression: fail");
    end
    $finish;
  end

endmodule
